// File: hdl/assert_macros.svh
// assertion macros used by the estimator core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: hdl/slcls_pkg.sv
// shared types and constants of the seasonal lag least squares estimator
package slcls_pkg;

   localparam int MAX_LAG           = 256;
   localparam int MAX_SERIES_LENGTH = 1048576;

   localparam int SAMPLE_W   = 12;
   localparam int LAG_W      = 9;
   localparam int ADDR_W     = $clog2(MAX_LAG);
   localparam int SEEN_W     = $clog2(MAX_SERIES_LENGTH + 1);
   localparam int SUM_W      = 32;
   localparam int SUM_SQ_W   = 44;
   localparam int WIDE_W     = 64;
   localparam int Q_W        = 32;
   localparam int FRAC_BITS  = 16;
   localparam int MUL_W      = 32;
   localparam int MUL_SPLIT  = 22;
   localparam int DVD_W      = WIDE_W + FRAC_BITS;
   localparam int DIV_STEPS  = DVD_W;
   localparam int STEP_W     = $clog2(DIV_STEPS + 1);

   localparam logic [Q_W-1:0] Q_POS_SAT = {1'b0, {(Q_W-1){1'b1}}};
   localparam logic [Q_W-1:0] Q_NEG_SAT = {1'b1, {(Q_W-1){1'b0}}};

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FEW      = 2'd1,
      STATUS_ZERO_DEN = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACC,
      ST_EVAL,
      ST_D1_LO,
      ST_D1_HI,
      ST_D2,
      ST_CMP,
      ST_A_HI,
      ST_B,
      ST_PHI_START,
      ST_PHI_WAIT,
      ST_LB,
      ST_LAM_START,
      ST_LAM_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic           done;
      logic           saturated;
      logic [Q_W-1:0] quotient;
   } div_result_type;

endpackage

// File: hdl/slcls_ram.sv
// generic simple dual port ram, registered read, old data on same address
module slcls_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/slcls_divider.sv
// bit-serial restoring divider, one quotient bit per cycle, saturation flag
module slcls_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [slcls_pkg::DVD_W-1:0]         dividend,
   input  logic [slcls_pkg::WIDE_W-1:0]        divisor,
   output slcls_pkg::div_result_type           result
);
   import slcls_pkg::*;

   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [WIDE_W-1:0] den_ff, den_in;
   logic [WIDE_W-1:0] rem_ff, rem_in;
   logic [Q_W-1:0]    q_ff, q_in;
   logic              ovf_ff, ovf_in;
   logic [WIDE_W:0]   shifted;
   logic [WIDE_W:0]   diff;
   logic              fits;

   always_comb begin
      shifted = {rem_ff, dvd_ff[DVD_W-1]};
      diff    = shifted - {1'b0, den_ff};
      fits    = shifted >= {1'b0, den_ff};
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      dvd_in  = dvd_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         cnt_in = STEP_W'(DIV_STEPS);
         dvd_in = dividend;
         den_in = divisor;
         rem_in = '0;
         q_in   = '0;
         ovf_in = 1'b0;
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? diff[WIDE_W-1:0] : shifted[WIDE_W-1:0];
         dvd_in  = {dvd_ff[DVD_W-2:0], 1'b0};
         q_in    = {q_ff[Q_W-2:0], fits};
         ovf_in  = ovf_ff | q_ff[Q_W-1];
         cnt_in  = cnt_ff - STEP_W'(1);
         done_in = (cnt_ff == STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
   end

   assign result.done      = done_ff;
   assign result.saturated = ovf_ff | q_ff[Q_W-1];
   assign result.quotient  = q_ff;

endmodule

// File: hdl/seasonal_lag_cls_estimator_core.sv
// top level of the seasonal lag conditional least squares estimator
//
// req channel: one count word per beat in req_tdata, req_tlast marks the
// last sample of a series. A sample is taken every cycle while no estimate
// is being worked out; each sample goes through the lag ram in one
// read-modify-write access and its pair is accumulated in the cycle after.
// rsp channel: one word per series, sent after the tlast sample. Too few
// samples and overflow are decided in ST_EVAL, a zero denominator in ST_CMP;
// a full estimate runs two 80-step bit-serial divisions (phi, then lambda)
// that share one divider, plus a shared 32x32 multiplier used over seven
// steps. req_tready is low from the tlast beat until the word is loaded.
// A finished word sits in the output register; a new series is accepted
// meanwhile; a stalled rsp_tready holds back the next estimate, and req_tready with it.
// csr_we writes the seasonal lag and clears the series in progress.
// reset: synchronous, lag back to 1, series cleared, no clearing pass over
// the lag ram since every entry is written before it is read.
module seasonal_lag_cls_estimator_core (
   input  logic        clock,
   input  logic        reset,
   // interval_count[11:0]
   input  logic [15:0] req_tdata,
   input  logic        req_tlast,
   input  logic        req_tvalid,
   output logic        req_tready,
   // phi_q16[31:0], lambda_q16[63:32]
   output logic [63:0] rsp_tdata,
   // estimate_status[1:0]
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_we,
   input  logic [slcls_pkg::LAG_W-1:0] csr_wdata
);
   import slcls_pkg::*;

   `include "assert_macros.svh"

   state_type state_ff, state_in;

   logic [LAG_W-1:0]    lag_ff, lag_in;
   logic [LAG_W-1:0]    lag_used;
   logic [ADDR_W-1:0]   ptr_ff, ptr_in;
   logic [SEEN_W-1:0]   seen_ff, seen_in;
   logic                ovf_ff, ovf_in;
   logic [SUM_W-1:0]    sum_cur_ff, sum_cur_in;
   logic [SUM_W-1:0]    sum_lag_ff, sum_lag_in;
   logic [SUM_SQ_W-1:0] sum_sq_ff, sum_sq_in;
   logic [SUM_SQ_W-1:0] sum_x_ff, sum_x_in;
   logic                pair_ff, pair_in;
   logic [SAMPLE_W-1:0] x_ff;

   logic                req_accept;
   logic                take;
   logic [ADDR_W-1:0]   ram_addr;
   logic [LAG_W-1:0]    ptr_next;
   logic [SAMPLE_W-1:0] ram_rdata;
   logic                clear_series;

   logic [MUL_W-1:0]    mul_a, mul_b;
   logic [WIDE_W-1:0]   mul_p;
   logic [WIDE_W-1:0]   prod_ff;
   logic [WIDE_W-1:0]   acc_ff, acc_in;
   logic [WIDE_W-1:0]   wide_ff, wide_in;
   logic [WIDE_W-1:0]   den_ff, den_in;
   logic [SEEN_W-1:0]   n_ff, n_in;
   logic                neg_ff, neg_in;
   logic [Q_W-1:0]      phi_ff, phi_in;
   logic [Q_W-1:0]      lam_ff, lam_in;
   status_type          status_ff, status_in;
   logic [Q_W-1:0]      pmag;
   logic [WIDE_W-1:0]   la;
   logic [WIDE_W-1:0]   signed_q;

   logic                div_start;
   logic [DVD_W-1:0]    div_dividend;
   logic [WIDE_W-1:0]   div_divisor;
   div_result_type      div_res;

   logic                out_load;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [Q_W-1:0]      rsp_phi_ff, rsp_lam_ff;
   status_type          rsp_status_ff;

   slcls_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_LAG)
   ) u_lag_line (
      .clock (clock),
      .we    (take),
      .waddr (ram_addr),
      .wdata (req_tdata[SAMPLE_W-1:0]),
      .raddr (ram_addr),
      .rdata (ram_rdata)
   );

   slcls_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .result   (div_res)
   );

   // sample path
   always_comb begin
      if (lag_ff == '0) begin
         lag_used = LAG_W'(1);
      end else if (lag_ff > LAG_W'(MAX_LAG)) begin
         lag_used = LAG_W'(MAX_LAG);
      end else begin
         lag_used = lag_ff;
      end
      req_tready = (state_ff == ST_IDLE);
      req_accept = req_tvalid & req_tready;
      take       = req_accept && !ovf_ff && (seen_ff < SEEN_W'(MAX_SERIES_LENGTH));
      ram_addr   = (LAG_W'(ptr_ff) < lag_used) ? ptr_ff : '0;
      ptr_next   = LAG_W'(ram_addr) + LAG_W'(1);

      lag_in     = csr_we ? csr_wdata : lag_ff;
      ptr_in     = ptr_ff;
      seen_in    = seen_ff;
      ovf_in     = ovf_ff;
      pair_in    = take && (seen_ff >= SEEN_W'(lag_used));
      sum_cur_in = sum_cur_ff;
      sum_lag_in = sum_lag_ff;
      sum_sq_in  = sum_sq_ff;
      sum_x_in   = sum_x_ff;

      if (req_accept && !ovf_ff && !take) begin
         ovf_in = 1'b1;
      end
      if (take) begin
         ptr_in  = (ptr_next >= lag_used) ? '0 : ptr_next[ADDR_W-1:0];
         seen_in = seen_ff + SEEN_W'(1);
      end
      if (pair_ff) begin
         sum_cur_in = sum_cur_ff + SUM_W'(x_ff);
         sum_lag_in = sum_lag_ff + SUM_W'(ram_rdata);
         sum_sq_in  = sum_sq_ff + SUM_SQ_W'(ram_rdata * ram_rdata);
         sum_x_in   = sum_x_ff + SUM_SQ_W'(ram_rdata * x_ff);
      end
      if (csr_we || clear_series) begin
         ptr_in     = '0;
         seen_in    = '0;
         ovf_in     = 1'b0;
         pair_in    = 1'b0;
         sum_cur_in = '0;
         sum_lag_in = '0;
         sum_sq_in  = '0;
         sum_x_in   = '0;
      end
   end

   // estimate sequencer
   always_comb begin
      state_in     = state_ff;
      mul_a        = '0;
      mul_b        = '0;
      acc_in       = acc_ff;
      wide_in      = wide_ff;
      den_in       = den_ff;
      n_in         = n_ff;
      neg_in       = neg_ff;
      phi_in       = phi_ff;
      lam_in       = lam_ff;
      status_in    = status_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      out_load     = 1'b0;
      clear_series = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      pmag         = phi_ff[Q_W-1] ? (Q_W'(0) - phi_ff) : phi_ff;
      la           = WIDE_W'({sum_cur_ff, {FRAC_BITS{1'b0}}});
      signed_q     = '0;

      if (div_res.saturated) begin
         signed_q[Q_W-1:0] = neg_ff ? Q_NEG_SAT : Q_POS_SAT;
      end else begin
         signed_q[Q_W-1:0] = neg_ff ? (Q_W'(0) - div_res.quotient) : div_res.quotient;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_tlast) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            phi_in = '0;
            lam_in = '0;
            n_in   = seen_ff - SEEN_W'(lag_used);
            if (ovf_ff) begin
               status_in = STATUS_OVERFLOW;
               state_in  = ST_OUT;
            end else if (seen_ff <= SEEN_W'(lag_used)) begin
               status_in = STATUS_FEW;
               state_in  = ST_OUT;
            end else begin
               status_in = STATUS_OK;
               state_in  = ST_D1_LO;
            end
         end
         ST_D1_LO: begin
            mul_a    = MUL_W'(n_ff);
            mul_b    = MUL_W'(sum_sq_ff[MUL_SPLIT-1:0]);
            state_in = ST_D1_HI;
         end
         ST_D1_HI: begin
            acc_in   = prod_ff;
            mul_a    = MUL_W'(n_ff);
            mul_b    = MUL_W'(sum_sq_ff[SUM_SQ_W-1:MUL_SPLIT]);
            state_in = ST_D2;
         end
         ST_D2: begin
            wide_in  = acc_ff + (prod_ff << MUL_SPLIT);
            mul_a    = sum_lag_ff;
            mul_b    = sum_lag_ff;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (wide_ff <= prod_ff) begin
               status_in = STATUS_ZERO_DEN;
               state_in  = ST_OUT;
            end else begin
               den_in   = wide_ff - prod_ff;
               mul_a    = MUL_W'(n_ff);
               mul_b    = MUL_W'(sum_x_ff[MUL_SPLIT-1:0]);
               state_in = ST_A_HI;
            end
         end
         ST_A_HI: begin
            acc_in   = prod_ff;
            mul_a    = MUL_W'(n_ff);
            mul_b    = MUL_W'(sum_x_ff[SUM_SQ_W-1:MUL_SPLIT]);
            state_in = ST_B;
         end
         ST_B: begin
            wide_in  = acc_ff + (prod_ff << MUL_SPLIT);
            mul_a    = sum_cur_ff;
            mul_b    = sum_lag_ff;
            state_in = ST_PHI_START;
         end
         ST_PHI_START: begin
            div_start   = 1'b1;
            div_divisor = den_ff;
            if (wide_ff >= prod_ff) begin
               neg_in       = 1'b0;
               div_dividend = {wide_ff - prod_ff, {FRAC_BITS{1'b0}}};
            end else begin
               neg_in       = 1'b1;
               div_dividend = {prod_ff - wide_ff, {FRAC_BITS{1'b0}}};
            end
            state_in = ST_PHI_WAIT;
         end
         ST_PHI_WAIT: begin
            if (div_res.done) begin
               phi_in   = signed_q[Q_W-1:0];
               state_in = ST_LB;
            end
         end
         ST_LB: begin
            mul_a    = pmag;
            mul_b    = sum_lag_ff;
            state_in = ST_LAM_START;
         end
         ST_LAM_START: begin
            div_start   = 1'b1;
            div_divisor = WIDE_W'(n_ff);
            if (phi_ff[Q_W-1]) begin
               neg_in       = 1'b0;
               div_dividend = DVD_W'(la + prod_ff);
            end else if (la >= prod_ff) begin
               neg_in       = 1'b0;
               div_dividend = DVD_W'(la - prod_ff);
            end else begin
               neg_in       = 1'b1;
               div_dividend = DVD_W'(prod_ff - la);
            end
            state_in = ST_LAM_WAIT;
         end
         ST_LAM_WAIT: begin
            if (div_res.done) begin
               lam_in   = signed_q[Q_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load     = 1'b1;
               clear_series = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lag_ff       <= LAG_W'(1);
         ptr_ff       <= '0;
         seen_ff      <= '0;
         ovf_ff       <= 1'b0;
         pair_ff      <= 1'b0;
         sum_cur_ff   <= '0;
         sum_lag_ff   <= '0;
         sum_sq_ff    <= '0;
         sum_x_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lag_ff       <= lag_in;
         ptr_ff       <= ptr_in;
         seen_ff      <= seen_in;
         ovf_ff       <= ovf_in;
         pair_ff      <= pair_in;
         sum_cur_ff   <= sum_cur_in;
         sum_lag_ff   <= sum_lag_in;
         sum_sq_ff    <= sum_sq_in;
         sum_x_ff     <= sum_x_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_accept) begin
         x_ff <= req_tdata[SAMPLE_W-1:0];
      end
      prod_ff   <= mul_p;
      acc_ff    <= acc_in;
      wide_ff   <= wide_in;
      den_ff    <= den_in;
      n_ff      <= n_in;
      neg_ff    <= neg_in;
      phi_ff    <= phi_in;
      lam_ff    <= lam_in;
      status_ff <= status_in;
      if (out_load) begin
         rsp_phi_ff    <= phi_ff;
         rsp_lam_ff    <= lam_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_lam_ff, rsp_phi_ff};
   assign rsp_tuser  = rsp_status_ff;

   `ASSERT_CLK(a_addr_in_lag, clock, reset, take |-> (LAG_W'(ram_addr) < lag_used), "lag ram address beyond lag")
   `ASSERT_CLK(a_last_to_acc, clock, reset, (req_accept && req_tlast) |=> (state_ff == ST_ACC), "tlast word did not start the estimate")
   `ASSERT_CLK(a_div_done_wait, clock, reset, div_res.done |-> (state_ff == ST_PHI_WAIT || state_ff == ST_LAM_WAIT), "divider finished outside a wait state")
   `ASSERT_NEVER(a_seen_bound, clock, reset, seen_ff > SEEN_W'(MAX_SERIES_LENGTH), "sample count beyond series length")

endmodule

// File: bench/seasonal_lag_cls_estimator_core_tb.sv
// self-checking testbench of the seasonal lag least squares estimator core
module seasonal_lag_cls_estimator_core_tb;
   import slcls_pkg::*;

   localparam int    RANDOM_SAMPLES = 950;
   localparam int    HOLD_CYCLES    = 600;
   localparam int    SETTLE_CYCLES  = 8;
   localparam int    DRAIN_CYCLES   = 250;
   localparam int    PLAN_ROWS      = 29;
   localparam longint LIMIT_TIME    = 64'd40_000_000;

   typedef enum logic {ROW_SAMPLE, ROW_LAG} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [11:0]  value;
      logic         last;
      logic         typed;
      status_type   status;
   } plan_row_type;

   typedef struct packed {
      logic [Q_W-1:0] phi_q16;
      logic [Q_W-1:0] lam_q16;
      status_type     status;
   } estimate_type;

   logic                clock;
   logic                reset;
   logic [15:0]         req_tdata;
   logic                req_tlast;
   logic                req_tvalid;
   logic                req_tready;
   logic [63:0]         rsp_tdata;
   logic [1:0]          rsp_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic                csr_we;
   logic [LAG_W-1:0]    csr_wdata;

   // lag model state
   logic [SAMPLE_W-1:0] lag_mem [MAX_LAG];
   int unsigned         wr_ptr;
   int unsigned         seen_cnt;
   int unsigned         lag_setting;
   logic [63:0]         sum_cur;
   logic [63:0]         sum_lag;
   logic [63:0]         sum_sq;
   logic [63:0]         sum_cross;
   bit                  series_overflow;

   estimate_type        estimates_due [$];
   int                  send_gap_max;
   int                  rsp_stall_max;
   bit                  hold_req;
   int                  samples_sent;
   int                  mismatches;
   int                  status_tally [4];

   plan_row_type directed_plan [PLAN_ROWS] = '{
      '{ROW_SAMPLE, 12'd0,    1'b1, 1'b1, STATUS_FEW},
      '{ROW_LAG,    12'd0,    1'b0, 1'b0, STATUS_OK},
      '{ROW_SAMPLE, 12'd7,    1'b0, 1'b0, STATUS_OK},
      '{ROW_SAMPLE, 12'd7,    1'b0, 1'b0, STATUS_OK},
      '{ROW_SAMPLE, 12'd7,    1'b1, 1'b1, STATUS_ZERO_DEN},
      '{ROW_SAMPLE, 12'd4095, 1'b0, 1'b0, STATUS_OK},
      '{ROW_SAMPLE, 12'd0,    1'b0, 1'b0, STATUS_OK},
      '{ROW_SAMPLE, 12'd4095, 1'b0, 1'b0, STATUS_OK},
      '{ROW_SAMPLE, 12'd0,    1'b1, 1'b0, STATUS_OK},
      '{ROW_LAG,    12'd2,    1'b0, 1'b0, STATUS_OK},
      '{ROW_SAMPLE, 12'd4094, 1'b0, 1'b0, STATUS_OK},
      '{ROW_SAMPLE, 12'd4095, 1'b0, 1'b0, STATUS_OK},
      '{ROW_SAMPLE, 12'd0,    1'b0, 1'b0, STATUS_OK},
      '{ROW_SAMPLE, 12'd4095, 1'b1, 1'b0, STATUS_OK},
      '{ROW_SAMPLE, 12'd4094, 1'b0, 1'b0, STATUS_OK},
      '{ROW_SAMPLE, 12'd4095, 1'b0, 1'b0, STATUS_OK},
      '{ROW_SAMPLE, 12'd4095, 1'b0, 1'b0, STATUS_OK},
      '{ROW_SAMPLE, 12'd0,    1'b1, 1'b0, STATUS_OK},
      '{ROW_LAG,    12'd511,  1'b0, 1'b0, STATUS_OK},
      '{ROW_SAMPLE, 12'd4095, 1'b0, 1'b0, STATUS_OK},
      '{ROW_SAMPLE, 12'd1,    1'b0, 1'b0, STATUS_OK},
      '{ROW_SAMPLE, 12'd4095, 1'b1, 1'b1, STATUS_FEW},
      '{ROW_LAG,    12'd3,    1'b0, 1'b0, STATUS_OK},
      '{ROW_SAMPLE, 12'd1,    1'b0, 1'b0, STATUS_OK},
      '{ROW_SAMPLE, 12'd2,    1'b0, 1'b0, STATUS_OK},
      '{ROW_SAMPLE, 12'd3,    1'b0, 1'b0, STATUS_OK},
      '{ROW_SAMPLE, 12'd5,    1'b0, 1'b0, STATUS_OK},
      '{ROW_SAMPLE, 12'd8,    1'b0, 1'b0, STATUS_OK},
      '{ROW_SAMPLE, 12'd13,   1'b1, 1'b0, STATUS_OK}
   };

   seasonal_lag_cls_estimator_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   initial begin
      #(LIMIT_TIME);
      $display("== FAIL ==");
      $finish;
   end

   function automatic int unsigned lag_in_use();
      if (lag_setting == 0) return 1;
      if (lag_setting > MAX_LAG) return MAX_LAG;
      return lag_setting;
   endfunction

   function automatic void restart_series();
      wr_ptr          = 0;
      seen_cnt        = 0;
      sum_cur         = '0;
      sum_lag         = '0;
      sum_sq          = '0;
      sum_cross       = '0;
      series_overflow = 1'b0;
   endfunction

   // truncated signed quotient mag * 2^fb / den, saturated to q16
   function automatic logic [Q_W-1:0] scaled_quotient(logic [63:0] mag, logic [63:0] den,
                                                      bit neg, int fb);
      logic [63:0] q0;
      logic [63:0] r;
      logic [63:0] q;
      bit          top;
      int          i;
      q0 = mag / den;
      r  = mag % den;
      if ((q0 >> (31 - fb)) != 0) return neg ? Q_NEG_SAT : Q_POS_SAT;
      q = q0;
      for (i = 0; i < fb; i++) begin
         top = r[63];
         r   = r << 1;
         q   = q << 1;
         if (top || r >= den) begin
            r    = r - den;
            q[0] = 1'b1;
         end
      end
      if (q == 0) return '0;
      return neg ? -q[31:0] : q[31:0];
   endfunction

   // advances the series by one sample, returns 1 with the estimate on the last one
   function automatic bit accumulate_sample(logic [SAMPLE_W-1:0] cnt, bit last,
                                            output estimate_type est);
      int unsigned    lag;
      int unsigned    p;
      logic [63:0]    old;
      logic [63:0]    n;
      logic [63:0]    d1;
      logic [63:0]    d2;
      logic [63:0]    a;
      logic [63:0]    b;
      logic [Q_W-1:0] phi_abs;
      logic [63:0]    la;
      logic [63:0]    lb;
      logic [63:0]    lmag;
      bit             lneg;
      lag = lag_in_use();
      est = '{phi_q16: '0, lam_q16: '0, status: STATUS_OK};
      if (!series_overflow) begin
         if (seen_cnt >= MAX_SERIES_LENGTH) begin
            series_overflow = 1'b1;
         end else begin
            p = (wr_ptr < lag && wr_ptr < MAX_LAG) ? wr_ptr : 0;
            if (seen_cnt >= lag) begin
               old       = 64'(lag_mem[p]);
               sum_cur   = sum_cur + 64'(cnt);
               sum_lag   = sum_lag + old;
               sum_sq    = sum_sq + old * old;
               sum_cross = sum_cross + old * 64'(cnt);
            end
            lag_mem[p] = cnt;
            p++;
            wr_ptr = (p >= lag) ? 0 : p;
            seen_cnt++;
         end
      end
      if (!last) return 1'b0;
      if (series_overflow) begin
         est.status = STATUS_OVERFLOW;
      end else if (seen_cnt <= lag) begin
         est.status = STATUS_FEW;
      end else begin
         n  = 64'(seen_cnt - lag);
         d1 = n * sum_sq;
         d2 = sum_lag * sum_lag;
         if (d1 <= d2) begin
            est.status = STATUS_ZERO_DEN;
         end else begin
            a = n * sum_cross;
            b = sum_cur * sum_lag;
            if (a >= b) est.phi_q16 = scaled_quotient(a - b, d1 - d2, 1'b0, FRAC_BITS);
            else est.phi_q16 = scaled_quotient(b - a, d1 - d2, 1'b1, FRAC_BITS);
            phi_abs = est.phi_q16[Q_W-1] ? -est.phi_q16 : est.phi_q16;
            la = sum_cur << FRAC_BITS;
            lb = {32'b0, phi_abs} * sum_lag;
            if (est.phi_q16[Q_W-1]) begin
               lmag = la + lb;
               lneg = 1'b0;
            end else if (la >= lb) begin
               lmag = la - lb;
               lneg = 1'b0;
            end else begin
               lmag = lb - la;
               lneg = 1'b1;
            end
            est.lam_q16 = scaled_quotient(lmag, n, lneg, 0);
         end
      end
      restart_series();
      return 1'b1;
   endfunction

   task automatic push_sample(input logic [SAMPLE_W-1:0] cnt, input logic last,
                              input bit typed = 1'b0, input status_type golden = STATUS_OK);
      int           gap;
      estimate_type est;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, cnt};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      samples_sent++;
      if (accumulate_sample(cnt, last, est)) begin
         if (typed) est = '{phi_q16: '0, lam_q16: '0, status: golden};
         estimates_due.push_back(est);
      end
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (estimates_due.size() != 0);
   endtask

   task automatic write_lag(input logic [LAG_W-1:0] value);
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      lag_setting = value;
      restart_series();
   endtask

   // result side
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      forever begin
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end
         stall = $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid && !hold_req);
      end
   end

   always @(posedge clock) begin
      estimate_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (estimates_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: phi %h lambda %h status %0d",
                        rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser);
         end else begin
            want = estimates_due.pop_front();
            status_tally[want.status]++;
            if (rsp_tdata[31:0] !== want.phi_q16 || rsp_tdata[63:32] !== want.lam_q16 ||
                rsp_tuser !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: phi %h/%h lambda %h/%h status %0d/%0d (expected/actual)",
                           want.phi_q16, rsp_tdata[31:0], want.lam_q16, rsp_tdata[63:32],
                           want.status, rsp_tuser);
            end
         end
      end
   end

   initial begin
      int                  k;
      int                  s;
      int                  len;
      int                  shape;
      int                  series_cnt;
      int                  phase;
      int                  random_items;
      int unsigned         eff_lag;
      logic [SAMPLE_W-1:0] cnt;
      logic [SAMPLE_W-1:0] base;
      logic [LAG_W-1:0]    new_lag;
      bit                  narrow;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      csr_we     <= 1'b0;
      csr_wdata  <= '0;
      hold_req      = 1'b0;
      send_gap_max  = 14;
      rsp_stall_max = 14;
      lag_setting   = 1;
      restart_series();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_LAG)
            write_lag(directed_plan[i].value[LAG_W-1:0]);
         else
            push_sample(directed_plan[i].value, directed_plan[i].last,
                        directed_plan[i].typed, directed_plan[i].status);
      end

      phase        = 0;
      random_items = 0;
      while (random_items < RANDOM_SAMPLES) begin
         if (phase == 0) new_lag = 9'd256;
         else if (phase == 1) new_lag = 9'($urandom_range(257, 511));
         else if ($urandom_range(0, 4) == 0) new_lag = 9'($urandom_range(9, 40));
         else new_lag = 9'($urandom_range(0, 8));
         write_lag(new_lag);
         eff_lag       = lag_in_use();
         send_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 14;
         rsp_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
         series_cnt    = (eff_lag > 40) ? 1 : $urandom_range(1, 6);
         if (phase == 2) begin
            series_cnt = 5;
            hold_req   = 1'b1;
         end
         for (s = 0; s < series_cnt; s++) begin
            if (phase == 0) shape = 2;
            else if (phase == 1) shape = 0;
            else shape = $urandom_range(0, 9);
            if (shape == 0) len = $urandom_range(1, (eff_lag > 30) ? 30 : eff_lag);
            else len = eff_lag + $urandom_range(1, 24);
            base   = 12'($urandom_range(0, 4095));
            narrow = $urandom_range(0, 1);
            for (k = 0; k < len; k++) begin
               if (shape == 1) cnt = base;
               else if (narrow) cnt = base ^ 12'($urandom_range(0, 3));
               else cnt = 12'($urandom_range(0, 4095));
               push_sample(cnt, k == len - 1);
               random_items++;
            end
            if ($urandom_range(0, 7) == 0) wait_for_results();
         end
         // unfinished series, dropped by the next lag write or left open at the end
         if ($urandom_range(0, 3) == 0) begin
            len = $urandom_range(1, eff_lag + 4);
            for (k = 0; k < len; k++) begin
               push_sample(12'($urandom_range(0, 4095)), 1'b0);
               random_items++;
            end
         end
         phase++;
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d samples in %0d phases, estimates: %0d ok, %0d too few, %0d zero den, %0d overflow",
               samples_sent, phase, status_tally[STATUS_OK], status_tally[STATUS_FEW],
               status_tally[STATUS_ZERO_DEN], status_tally[STATUS_OVERFLOW]);
      $display("lags 0 to 511 incl. clamping, long result hold-off, %0d mismatches, %0d left over",
               mismatches, estimates_due.size());
      if (mismatches == 0 && estimates_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: seasonal_lag_cls_estimator_core.f
+incdir+hdl
hdl/slcls_pkg.sv
hdl/slcls_ram.sv
hdl/slcls_divider.sv
hdl/seasonal_lag_cls_estimator_core.sv
bench/seasonal_lag_cls_estimator_core_tb.sv
